// ===== hdl/bmf_pkg.sv =====
// Shared types and codes for the bitmap store with find-first.
// No dependencies; used by the top level and the byte finder.
`default_nettype none

package bmf_pkg;

	typedef logic [2:0]  mode_t;
	typedef logic [10:0] cnt_t;
	typedef logic [8:0]  byte_cnt_t;
	typedef logic [9:0]  pos_t;
	typedef logic [11:0] lim_t;

	localparam mode_t MODE_SET      = 3'd0;
	localparam mode_t MODE_CLEAR    = 3'd1;
	localparam mode_t MODE_FLIP     = 3'd2;
	localparam mode_t MODE_TEST     = 3'd3;
	localparam mode_t MODE_FILL     = 3'd4;
	localparam mode_t MODE_FIND_SET = 3'd5;
	localparam mode_t MODE_FIND_CLR = 3'd6;

	localparam cnt_t BITS_RESET = 11'd1024;

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_READ   = 7'b0000100,
		ST_MODIFY = 7'b0001000,
		ST_FILL   = 7'b0010000,
		ST_SCAN   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] pos;
	} find_res_t;

endpackage

`default_nettype wire

// ===== hdl/bitmap_store_with_find_first.sv =====
// Bitmap store with set, clear, flip, test, fill and find-first over a byte RAM.
// Depends on bmf_pkg and bmf_byte_find.
//
// Usage:
//   Input words (mode, bit_index, fill_pattern) enter on in_valid/in_stall and
//   each yields one result word (bit_value, found, position, index_error) on
//   out_valid/out_stall. One word is worked on at a time; the next is taken
//   as soon as the previous one has moved into the output register.
//   RAM work per word, with n = min(bits_in_use, MAX_BITS):
//     set, clear, flip in range: one read and one write of the RAM
//     test in range: one read; out-of-range index, unused mode: none
//     fill: ceil(n/8) bytes, one RAM byte written per cycle
//     find: bytes read in order up to a hit, else all ceil(n/8)
//   After reset the RAM is swept to zero, one byte per cycle, (MAX_BITS+7)/8
//   bytes (128 by default); in_stall stays high meanwhile. bits_in_use resets
//   to 1024 and is written through cfg_wr_en/cfg_wr_data; it must be written
//   only while idle, which the block does not enforce. A stalled result holds
//   in the output register; one further word may be accepted and worked on,
//   and it waits for the output register to free.
`default_nettype none

module bitmap_store_with_find_first #(
	parameter int MAX_BITS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [9:0]  bit_index,
	input  wire logic [7:0]  fill_pattern,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             bit_value,
	output logic             found,
	output logic [9:0]       position,
	output logic             index_error
);

	localparam int DEPTH = (MAX_BITS + 7) / 8;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef logic [AW-1:0] addr_t;

	bmf_pkg::state_t    state_q;
	bmf_pkg::cnt_t      bits_q;
	bmf_pkg::cnt_t      n;
	bmf_pkg::byte_cnt_t nbytes;

	bmf_pkg::mode_t     mode_q;
	logic [9:0]         idx_q;
	logic [7:0]         pat_q;
	addr_t              clr_q;
	bmf_pkg::byte_cnt_t k_q;
	bmf_pkg::byte_cnt_t k_s1;
	logic               rd_v_s1;

	logic               res_bit_q;
	logic               res_found_q;
	bmf_pkg::pos_t      res_pos_q;
	logic               res_err_q;

	logic [7:0]         mem [DEPTH];
	logic [7:0]         rd_data_q;
	logic               rd_en;
	addr_t              rd_addr;
	logic               wr_en;
	addr_t              wr_addr;
	logic [7:0]         wr_data;

	logic               accept;
	logic               done_fire;
	logic [7:0]         bit_mask;
	bmf_pkg::lim_t      lim;
	bmf_pkg::lim_t      hit_pos;
	bmf_pkg::find_res_t fr;
	logic               scan_hit;

	assign n = (32'(bits_q) > 32'(MAX_BITS)) ? bmf_pkg::cnt_t'(MAX_BITS) : bits_q;
	assign nbytes = bmf_pkg::byte_cnt_t'((bmf_pkg::lim_t'(n) + 12'd7) >> 3);

	assign in_stall  = !(state_q == bmf_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign done_fire = (state_q == bmf_pkg::ST_DONE) && (!out_valid || !out_stall);

	assign bit_mask = 8'(1) << idx_q[2:0];
	assign lim      = bmf_pkg::lim_t'(n) - {k_s1, 3'b000};
	assign hit_pos  = {k_s1, 3'b000} + bmf_pkg::lim_t'(fr.pos);
	assign scan_hit = rd_v_s1 && fr.hit;

	bmf_byte_find u_find (
		.byte_in  (rd_data_q),
		.want_set (mode_q == bmf_pkg::MODE_FIND_SET),
		.lim      (lim),
		.res      (fr)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_t'(idx_q[9:3]);
		wr_en   = 1'b0;
		wr_addr = addr_t'(idx_q[9:3]);
		wr_data = rd_data_q;
		case (state_q)
			bmf_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = 8'd0;
			end
			bmf_pkg::ST_READ: begin
				rd_en = 1'b1;
			end
			bmf_pkg::ST_MODIFY: begin
				case (mode_q)
					bmf_pkg::MODE_SET: begin
						wr_en   = 1'b1;
						wr_data = rd_data_q | bit_mask;
					end
					bmf_pkg::MODE_CLEAR: begin
						wr_en   = 1'b1;
						wr_data = rd_data_q & ~bit_mask;
					end
					bmf_pkg::MODE_FLIP: begin
						wr_en   = 1'b1;
						wr_data = rd_data_q ^ bit_mask;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			bmf_pkg::ST_FILL: begin
				wr_en   = (k_q < nbytes);
				wr_addr = addr_t'(k_q);
				wr_data = pat_q;
			end
			bmf_pkg::ST_SCAN: begin
				rd_en   = !scan_hit && (k_q < nbytes);
				rd_addr = addr_t'(k_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= bmf_pkg::BITS_RESET;
		end else if (cfg_wr_en) begin
			bits_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmf_pkg::ST_CLEAR;
			clr_q   <= '0;
			k_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				bmf_pkg::ST_CLEAR: begin
					clr_q <= clr_q + addr_t'(1);
					if (clr_q == addr_t'(DEPTH - 1)) begin
						state_q <= bmf_pkg::ST_IDLE;
					end
				end
				bmf_pkg::ST_IDLE: begin
					k_q     <= '0;
					rd_v_s1 <= 1'b0;
					if (accept) begin
						case (mode) inside
							bmf_pkg::MODE_SET, bmf_pkg::MODE_CLEAR,
							bmf_pkg::MODE_FLIP, bmf_pkg::MODE_TEST: begin
								if (bmf_pkg::cnt_t'(bit_index) >= n) begin
									state_q <= bmf_pkg::ST_DONE;
								end else begin
									state_q <= bmf_pkg::ST_READ;
								end
							end
							bmf_pkg::MODE_FILL: begin
								state_q <= bmf_pkg::ST_FILL;
							end
							bmf_pkg::MODE_FIND_SET, bmf_pkg::MODE_FIND_CLR: begin
								state_q <= bmf_pkg::ST_SCAN;
							end
							default: begin
								state_q <= bmf_pkg::ST_DONE;
							end
						endcase
					end
				end
				bmf_pkg::ST_READ: begin
					state_q <= bmf_pkg::ST_MODIFY;
				end
				bmf_pkg::ST_MODIFY: begin
					state_q <= bmf_pkg::ST_DONE;
				end
				bmf_pkg::ST_FILL: begin
					if (k_q < nbytes) begin
						k_q <= k_q + bmf_pkg::byte_cnt_t'(1);
					end else begin
						state_q <= bmf_pkg::ST_DONE;
					end
				end
				bmf_pkg::ST_SCAN: begin
					if (scan_hit) begin
						state_q <= bmf_pkg::ST_DONE;
					end else if (k_q < nbytes) begin
						k_q     <= k_q + bmf_pkg::byte_cnt_t'(1);
						rd_v_s1 <= 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) begin
							state_q <= bmf_pkg::ST_DONE;
						end
					end
				end
				bmf_pkg::ST_DONE: begin
					if (done_fire) begin
						state_q <= bmf_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= bmf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= mode;
			idx_q       <= bit_index;
			pat_q       <= fill_pattern;
			res_bit_q   <= 1'b0;
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
			case (mode) inside
				bmf_pkg::MODE_SET, bmf_pkg::MODE_CLEAR,
				bmf_pkg::MODE_FLIP, bmf_pkg::MODE_TEST: begin
					res_err_q <= (bmf_pkg::cnt_t'(bit_index) >= n);
				end
				default: begin
					res_err_q <= 1'b0;
				end
			endcase
		end
		if (state_q == bmf_pkg::ST_SCAN) begin
			k_s1 <= k_q;
		end
		if (state_q == bmf_pkg::ST_MODIFY) begin
			res_bit_q <= rd_data_q[idx_q[2:0]];
		end
		if ((state_q == bmf_pkg::ST_SCAN) && scan_hit) begin
			res_found_q <= 1'b1;
			res_pos_q   <= bmf_pkg::pos_t'(hit_pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (done_fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			bit_value   <= res_bit_q;
			found       <= res_found_q;
			position    <= res_pos_q;
			index_error <= res_err_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bmf_byte_find.sv =====
// Lowest matching bit of one store byte, limited to the bits still in use.
// Depends on bmf_pkg.
`default_nettype none

module bmf_byte_find (
	input  wire logic [7:0]         byte_in,
	input  wire logic               want_set,
	input  wire bmf_pkg::lim_t      lim,
	output bmf_pkg::find_res_t      res
);

	logic [7:0] match;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			match[j] = (byte_in[j] == want_set) && (bmf_pkg::lim_t'(j) < lim);
		end
	end

	always_comb begin
		res.hit = |match;
		res.pos = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (match[j]) begin
				res.pos = 3'(j);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bmf_checker.sv =====
// Port-level checks for the bitmap store, bound to the top level.
// Depends on bitmap_store_with_find_first's ports only.
`default_nettype none

module bmf_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        bit_value,
	input wire logic        found,
	input wire logic [9:0]  position,
	input wire logic        index_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bit_value) && $stable(found)
			&& $stable(position) && $stable(index_error))
		else $error("stalled result word changed");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while one is in progress");

	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !bit_value && !index_error)
		else $error("find result carries access fields");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> !bit_value && !found && (position == 10'd0))
		else $error("rejected access reports data");

	a_miss_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == 10'd0)
		else $error("position nonzero without a hit");

endmodule

bind bitmap_store_with_find_first bmf_port_checks u_bmf_port_checks (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.bit_value   (bit_value),
	.found       (found),
	.position    (position),
	.index_error (index_error)
);

`default_nettype wire
